// File: rtl/core/sbt_pkg.sv
package sbt_pkg;

  localparam int NAME_LIMIT = 255;
  localparam int TEXT_LIMIT = 1023;

  localparam int LINE_W = 16;
  localparam int COL_W  = 16;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 10;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};
  localparam logic [OFF_W-1:0]  OFF_MAX  = {OFF_W{1'b1}};

  localparam logic [LEN_W-1:0] NAME_LIMIT_L = LEN_W'(NAME_LIMIT);
  localparam logic [LEN_W-1:0] TEXT_LIMIT_L = LEN_W'(TEXT_LIMIT);

  localparam logic [55:0] KW_FN      = 56'h666E;
  localparam logic [55:0] KW_PRINT   = 56'h7072696E74;
  localparam logic [55:0] KW_PRINTLN = 56'h7072696E746C6E;
  localparam logic [55:0] KW_RETURN  = 56'h72657475726E;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  typedef enum logic [3:0] {
    K_FN       = 4'd0,
    K_PRINT    = 4'd1,
    K_PRINTLN  = 4'd2,
    K_INT      = 4'd3,
    K_IDENT    = 4'd4,
    K_LPAR     = 4'd5,
    K_RPAR     = 4'd6,
    K_SEMI     = 4'd7,
    K_LBRC     = 4'd8,
    K_RBRC     = 4'd9,
    K_STRING   = 4'd10,
    K_AT       = 4'd11,
    K_RETURN   = 4'd12,
    K_EOF      = 4'd13,
    K_OPEN_STR = 4'd14,
    K_BAD_CHAR = 4'd15
  } kind_t;

  typedef struct packed {
    logic              last;
    logic [LEN_W-1:0]  text_length;
    logic [OFF_W-1:0]  start_offset;
    logic [COL_W-1:0]  start_column;
    logic [LINE_W-1:0] start_line;
    kind_t             kind;
  } result_t;

endpackage

// File: rtl/core/source_byte_tokenizer_top.sv
// channel   dir  beat fields (tdata from bit 0 up)                        tlast
// s_axis    in   ch[7:0]                                                  -
// m_axis    out  kind[3:0] line[19:4] column[35:20] offset[59:36]         last
//                length[69:60] zeros[71:70]
// one byte is taken per cycle while s_tready is high; its state update and up to
// two results are formed in the same cycle and written into a four-entry result queue
// s_tready is high while the queue has room for two results, so bytes that
// cause two results slow intake only when the output side stalls
// rst (synchronous) returns to idle at line 1, column 1, offset 0 and empties the queue
module source_byte_tokenizer_top
  import sbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // kind, start_line, start_column, start_offset, text_length
  output logic        m_tlast    // last
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_NUMBER,
    M_STRING,
    M_SKIP
  } mode_t;

  mode_t             mode, mode_next;
  logic [LINE_W-1:0] cur_line, cur_line_next, tok_line, tok_line_next;
  logic [COL_W-1:0]  cur_column, cur_column_next, tok_column, tok_column_next;
  logic [OFF_W-1:0]  cur_offset, cur_offset_next, tok_offset, tok_offset_next;
  logic [LEN_W-1:0]  run_length, run_length_next;
  logic [55:0]       word_prefix, word_prefix_next;

  result_t           queue [4];
  logic [1:0]        wp, rp;
  logic [2:0]        count;

  logic              accept, pop;
  logic [7:0]        ch;
  logic              is_letter, is_digit;
  logic [LINE_W-1:0] adv_line;
  logic [COL_W-1:0]  adv_column;
  logic [OFF_W-1:0]  adv_offset;
  kind_t             word_kind;

  // idle path
  logic              idle_emit;
  result_t           idle_res;
  mode_t             idle_mode;
  logic              idle_adv, idle_begin, idle_restart;
  logic [LEN_W-1:0]  idle_run;
  logic [55:0]       idle_prefix;

  logic [1:0]        n;
  result_t           res0, res1;
  logic              go_idle, do_adv, do_restart;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= 3'd2);
  assign m_tvalid = (count != 3'd0);
  assign ch       = s_tdata;

  assign m_tdata  = {2'b00, queue[rp].text_length, queue[rp].start_offset,
                     queue[rp].start_column, queue[rp].start_line, queue[rp].kind};
  assign m_tlast  = queue[rp].last;

  assign is_letter = (ch inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  assign is_digit  = (ch inside {[8'h30:8'h39]});

  assign adv_offset = (cur_offset < OFF_MAX) ? cur_offset + 1'b1 : cur_offset;
  assign adv_line   = (ch == CH_NL && cur_line < LINE_MAX) ? cur_line + 1'b1 : cur_line;
  assign adv_column = (ch == CH_NL) ? COL_W'(1) :
                      (cur_column < COL_MAX) ? cur_column + 1'b1 : cur_column;

  always_comb begin
    word_kind = K_IDENT;
    if (run_length == LEN_W'(2) && word_prefix == KW_FN) word_kind = K_FN;
    else if (run_length == LEN_W'(5) && word_prefix == KW_PRINT) word_kind = K_PRINT;
    else if (run_length == LEN_W'(7) && word_prefix == KW_PRINTLN) word_kind = K_PRINTLN;
    else if (run_length == LEN_W'(6) && word_prefix == KW_RETURN) word_kind = K_RETURN;
  end

  always_comb begin
    idle_emit    = 1'b0;
    idle_mode    = M_IDLE;
    idle_adv     = 1'b0;
    idle_begin   = 1'b0;
    idle_restart = 1'b0;
    idle_run     = run_length;
    idle_prefix  = word_prefix;
    idle_res     = '{last: 1'b1, text_length: '0, start_offset: cur_offset,
                     start_column: cur_column, start_line: cur_line, kind: K_BAD_CHAR};
    case (ch)
      CH_LPAR: begin idle_emit = 1'b1; idle_adv = 1'b1; idle_res.kind = K_LPAR; end
      CH_RPAR: begin idle_emit = 1'b1; idle_adv = 1'b1; idle_res.kind = K_RPAR; end
      CH_SEMI: begin idle_emit = 1'b1; idle_adv = 1'b1; idle_res.kind = K_SEMI; end
      CH_LBRC: begin idle_emit = 1'b1; idle_adv = 1'b1; idle_res.kind = K_LBRC; end
      CH_RBRC: begin idle_emit = 1'b1; idle_adv = 1'b1; idle_res.kind = K_RBRC; end
      CH_AT:   begin idle_emit = 1'b1; idle_adv = 1'b1; idle_res.kind = K_AT; end
      CH_NL, CH_SPACE, CH_TAB: begin
        idle_adv = 1'b1;
      end
      CH_NUL: begin
        idle_emit     = 1'b1;
        idle_restart  = 1'b1;
        idle_res.kind = K_EOF;
      end
      CH_QUOTE: begin
        idle_begin = 1'b1;
        idle_adv   = 1'b1;
        idle_run   = '0;
        idle_mode  = M_STRING;
      end
      default: begin
        if (is_letter) begin
          idle_begin  = 1'b1;
          idle_adv    = 1'b1;
          idle_run    = LEN_W'(1);
          idle_prefix = {48'h0, ch};
          idle_mode   = M_WORD;
        end else if (is_digit) begin
          idle_begin = 1'b1;
          idle_adv   = 1'b1;
          idle_run   = LEN_W'(1);
          idle_mode  = M_NUMBER;
        end else begin
          idle_emit     = 1'b1;
          idle_mode     = M_SKIP;
          idle_res.kind = K_BAD_CHAR;
        end
      end
    endcase
  end

  always_comb begin
    n                = 2'd0;
    res0             = idle_res;
    res1             = idle_res;
    go_idle          = 1'b0;
    do_adv           = 1'b0;
    do_restart       = 1'b0;
    mode_next        = mode;
    run_length_next  = run_length;
    word_prefix_next = word_prefix;
    tok_line_next    = tok_line;
    tok_column_next  = tok_column;
    tok_offset_next  = tok_offset;

    case (mode)
      M_WORD: begin
        if (is_letter && run_length < NAME_LIMIT_L) begin
          if (run_length < LEN_W'(7)) word_prefix_next = {word_prefix[47:0], ch};
          run_length_next = run_length + 1'b1;
          do_adv          = 1'b1;
        end else begin
          res0 = '{last: 1'b0, text_length: run_length, start_offset: tok_offset,
                   start_column: tok_column, start_line: tok_line, kind: word_kind};
          n       = 2'd1;
          go_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit && run_length < TEXT_LIMIT_L) begin
          run_length_next = run_length + 1'b1;
          do_adv          = 1'b1;
        end else begin
          res0 = '{last: 1'b0, text_length: run_length, start_offset: tok_offset,
                   start_column: tok_column, start_line: tok_line, kind: K_INT};
          n       = 2'd1;
          go_idle = 1'b1;
        end
      end
      M_STRING: begin
        res0 = '{last: 1'b1, text_length: '0, start_offset: tok_offset,
                 start_column: tok_column, start_line: tok_line, kind: K_OPEN_STR};
        if (ch == CH_QUOTE) begin
          res0.kind        = K_STRING;
          res0.text_length = run_length;
          n                = 2'd1;
          do_adv           = 1'b1;
          mode_next        = M_IDLE;
        end else if (ch == CH_NUL) begin
          n          = 2'd1;
          do_restart = 1'b1;
        end else if (run_length >= TEXT_LIMIT_L) begin
          n         = 2'd1;
          mode_next = M_SKIP;
        end else begin
          run_length_next = run_length + 1'b1;
          do_adv          = 1'b1;
        end
      end
      M_SKIP: begin
        if (ch == CH_NUL) do_restart = 1'b1;
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      mode_next        = idle_mode;
      run_length_next  = idle_run;
      word_prefix_next = idle_prefix;
      do_adv           = idle_adv;
      do_restart       = idle_restart;
      if (idle_begin) begin
        tok_line_next   = cur_line;
        tok_column_next = cur_column;
        tok_offset_next = cur_offset;
      end
      if (idle_emit) begin
        if (n == 2'd1) begin
          res1 = idle_res;
          n    = 2'd2;
        end else begin
          res0 = idle_res;
          n    = 2'd1;
        end
      end else if (n == 2'd1) begin
        res0.last = 1'b1;
      end
    end

    cur_line_next   = cur_line;
    cur_column_next = cur_column;
    cur_offset_next = cur_offset;
    if (do_restart) begin
      mode_next       = M_IDLE;
      cur_line_next   = LINE_W'(1);
      cur_column_next = COL_W'(1);
      cur_offset_next = '0;
    end else if (do_adv) begin
      cur_line_next   = adv_line;
      cur_column_next = adv_column;
      cur_offset_next = adv_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      cur_line    <= LINE_W'(1);
      cur_column  <= COL_W'(1);
      cur_offset  <= '0;
      tok_line    <= LINE_W'(1);
      tok_column  <= COL_W'(1);
      tok_offset  <= '0;
      run_length  <= '0;
      word_prefix <= '0;
      wp          <= '0;
      rp          <= '0;
      count       <= '0;
    end else begin
      if (accept) begin
        mode        <= mode_next;
        cur_line    <= cur_line_next;
        cur_column  <= cur_column_next;
        cur_offset  <= cur_offset_next;
        tok_line    <= tok_line_next;
        tok_column  <= tok_column_next;
        tok_offset  <= tok_offset_next;
        run_length  <= run_length_next;
        word_prefix <= word_prefix_next;
        wp          <= wp + n;
      end
      if (pop) rp <= rp + 1'b1;
      count <= count + (accept ? {1'b0, n} : 3'd0) - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n != 2'd0) queue[wp] <= res0;
    if (accept && n == 2'd2) queue[wp + 1'b1] <= res1;
  end

  // queue never overflows
  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overflow");

  // a byte in the error state other than zero leaves position unchanged
  assert property (@(posedge clk) disable iff (rst)
    accept && mode == M_SKIP && s_tdata != CH_NUL |=> $stable(cur_offset) && mode == M_SKIP)
    else $error("error state left on nonzero byte");

  // a zero byte always rewinds the position
  assert property (@(posedge clk) disable iff (rst)
    accept && s_tdata == CH_NUL |=> cur_offset == '0 && cur_line == LINE_W'(1))
    else $error("end of source did not rewind");

  // a queued result that is not taken stays at the head
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(rp))
    else $error("queue head moved while stalled");

endmodule

// File: tb/source_byte_tokenizer_top_tb.sv
module source_byte_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbt_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_BYTES = 650;
  localparam int LONG_HOLD    = 400;

  typedef enum logic [2:0] {LX_IDLE, LX_WORD, LX_NUMBER, LX_STRING, LX_SKIP} lex_mode_t;

  class token_scoreboard;
    result_t           tokens_due[$];
    lex_mode_t         mode;
    logic [LINE_W-1:0] line, tok_line;
    logic [COL_W-1:0]  column, tok_column;
    logic [OFF_W-1:0]  offset, tok_offset;
    int                run_len;
    logic [55:0]       prefix;
    int                errors;

    function new();
      restart();
      tok_line   = 1;
      tok_column = 1;
      tok_offset = 0;
      run_len    = 0;
      prefix     = 0;
      errors     = 0;
    endfunction

    function void restart();
      mode   = LX_IDLE;
      line   = 1;
      column = 1;
      offset = 0;
    endfunction

    function bit is_letter(logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function bit is_digit(logic [7:0] ch);
      return ch >= "0" && ch <= "9";
    endfunction

    function void advance(logic [7:0] ch);
      if (offset != OFF_MAX) offset++;
      if (ch == CH_NL) begin
        if (line != LINE_MAX) line++;
        column = 1;
      end else if (column != COL_MAX) begin
        column++;
      end
    endfunction

    function void start_token();
      tok_line   = line;
      tok_column = column;
      tok_offset = offset;
    endfunction

    function void emit(kind_t k, logic [LINE_W-1:0] l, logic [COL_W-1:0] c,
                       logic [OFF_W-1:0] o, int len);
      result_t r;
      r.kind         = k;
      r.start_line   = l;
      r.start_column = c;
      r.start_offset = o;
      r.text_length  = LEN_W'(len);
      r.last         = 1'b0;
      tokens_due.push_back(r);
    endfunction

    function kind_t word_kind();
      if (run_len == 2 && prefix == KW_FN) return K_FN;
      if (run_len == 5 && prefix == KW_PRINT) return K_PRINT;
      if (run_len == 7 && prefix == KW_PRINTLN) return K_PRINTLN;
      if (run_len == 6 && prefix == KW_RETURN) return K_RETURN;
      return K_IDENT;
    endfunction

    function void from_idle(logic [7:0] ch);
      kind_t k;
      bit    punct;
      mode  = LX_IDLE;
      punct = 1'b1;
      k     = K_LPAR;
      case (ch)
        CH_LPAR: k = K_LPAR;
        CH_RPAR: k = K_RPAR;
        CH_SEMI: k = K_SEMI;
        CH_LBRC: k = K_LBRC;
        CH_RBRC: k = K_RBRC;
        CH_AT:   k = K_AT;
        default: punct = 1'b0;
      endcase
      if (punct) begin
        emit(k, line, column, offset, 0);
        advance(ch);
      end else if (ch == CH_NL || ch == CH_SPACE || ch == CH_TAB) begin
        advance(ch);
      end else if (ch == CH_NUL) begin
        emit(K_EOF, line, column, offset, 0);
        restart();
      end else if (ch == CH_QUOTE) begin
        start_token();
        run_len = 0;
        mode    = LX_STRING;
        advance(ch);
      end else if (is_letter(ch)) begin
        start_token();
        run_len = 1;
        prefix  = {48'd0, ch};
        mode    = LX_WORD;
        advance(ch);
      end else if (is_digit(ch)) begin
        start_token();
        run_len = 1;
        mode    = LX_NUMBER;
        advance(ch);
      end else begin
        emit(K_BAD_CHAR, line, column, offset, 0);
        mode = LX_SKIP;
      end
    endfunction

    // accepted input beat: append the tokens it completes
    function void take_byte(logic [7:0] ch);
      int n;
      n = tokens_due.size();
      case (mode)
        LX_WORD: begin
          if (is_letter(ch) && run_len < NAME_LIMIT) begin
            if (run_len < 7) prefix = {prefix[47:0], ch};
            run_len++;
            advance(ch);
          end else begin
            emit(word_kind(), tok_line, tok_column, tok_offset, run_len);
            from_idle(ch);
          end
        end
        LX_NUMBER: begin
          if (is_digit(ch) && run_len < TEXT_LIMIT) begin
            run_len++;
            advance(ch);
          end else begin
            emit(K_INT, tok_line, tok_column, tok_offset, run_len);
            from_idle(ch);
          end
        end
        LX_STRING: begin
          if (ch == CH_QUOTE) begin
            emit(K_STRING, tok_line, tok_column, tok_offset, run_len);
            advance(ch);
            mode = LX_IDLE;
          end else if (ch == CH_NUL) begin
            emit(K_OPEN_STR, tok_line, tok_column, tok_offset, 0);
            restart();
          end else if (run_len >= TEXT_LIMIT) begin
            emit(K_OPEN_STR, tok_line, tok_column, tok_offset, 0);
            mode = LX_SKIP;
          end else begin
            run_len++;
            advance(ch);
          end
        end
        LX_SKIP: begin
          if (ch == CH_NUL) restart();
        end
        default: begin
          from_idle(ch);
        end
      endcase
      if (tokens_due.size() > n) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void match_token(logic [71:0] data, logic tlast);
      result_t want;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, expected nothing actual %h last %b",
                 $time, data, tlast);
        return;
      end
      want = tokens_due.pop_front();
      compare("kind", want.kind, data[3:0]);
      compare("start_line", want.start_line, data[19:4]);
      compare("start_column", want.start_column, data[35:20]);
      compare("start_offset", want.start_offset, data[59:36]);
      compare("text_length", want.text_length, data[69:60]);
      compare("pad bits", 0, data[71:70]);
      compare("last", want.last, tlast);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tlast;

  token_scoreboard sb = new();

  int tx_gap_max  = 17;
  int rx_gap_max  = 17;
  int rx_hold     = 0;
  int live_bytes  = 0;
  int idle_cycles = 0;

  string      spellings[10] = '{"fn", "print", "println", "return", "fnx", "prin",
                                "printlnx", "Return", "retur", "printl"};
  logic [7:0] punct_bytes[6] = '{CH_LPAR, CH_RPAR, CH_SEMI, CH_LBRC, CH_RBRC, CH_AT};
  logic [7:0] blank_bytes[3] = '{CH_SPACE, CH_TAB, CH_NL};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  source_byte_tokenizer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] content_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) return CH_NL;
    do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (sb.is_letter(b) || sb.is_digit(b) || b == CH_TAB || b == CH_NL ||
           b == CH_SPACE || b == CH_QUOTE || b == CH_LPAR || b == CH_RPAR ||
           b == CH_SEMI || b == CH_AT || b == CH_LBRC || b == CH_RBRC);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] ch);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.mode != LX_SKIP) live_bytes++;
    sb.take_byte(ch);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.tokens_due.size() != 0);
  endtask

  task automatic send_piece();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 260) : $urandom_range(1, 12);
      repeat (len) send_byte(any_letter());
    end else if (pick < 30) begin
      send_text(spellings[$urandom_range(0, 9)]);
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 6)) send_byte(any_digit());
    end else if (pick < 55) begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 8)) send_byte(content_byte());
      send_byte(CH_QUOTE);
    end else if (pick < 75) begin
      send_byte(punct_bytes[$urandom_range(0, 5)]);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) send_byte(blank_bytes[$urandom_range(0, 2)]);
    end else if (pick < 94) begin
      send_byte(CH_NUL);
    end else if (pick < 97) begin
      send_byte(stray_byte());
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) send_byte(CH_NUL);
    end else begin
      // string left open at end of source
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 5)) send_byte(content_byte());
      send_byte(CH_NUL);
    end
  endtask

  initial begin
    int hold;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = $urandom_range(0, rx_gap_max);
      if (rx_hold > 0) begin
        hold    = rx_hold;
        rx_hold = 0;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.match_token(m_tdata, m_tlast);
      @(negedge clk);
    end
  end

  initial begin
    bit held;
    bit paused;
    held     = 1'b0;
    paused   = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // keywords, all punctuation but ')', string over a newline, bad char and skip
    send_text("fn(print{println;return}@x9\"\n\"\t");
    send_byte(8'h80);
    send_byte("z");
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    send_text("\"ab");
    send_byte(CH_NUL);
    wait_drained();

    // length limits at full rate
    tx_gap_max = 0;
    rx_gap_max = 0;
    repeat (NAME_LIMIT + 1) send_byte(any_letter());
    send_byte(CH_SPACE);
    send_byte(CH_QUOTE);
    repeat (TEXT_LIMIT) send_byte(content_byte());
    send_text("xy");
    send_byte(CH_NUL);
    tx_gap_max = 17;
    rx_gap_max = 17;
    wait_drained();

    live_bytes = 0;
    while (live_bytes < RANDOM_BYTES) begin
      if (!held && live_bytes > RANDOM_BYTES / 3) begin
        held    = 1'b1;
        rx_hold = LONG_HOLD;
      end
      if (!paused && live_bytes > 2 * RANDOM_BYTES / 3) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 39) == 0) begin
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      end
      send_piece();
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.tokens_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
